// ===== sv/bstk_pkg.sv =====
`default_nettype none

package bstk_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_PEEK   = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_INSERT = 3'd4;
    localparam logic [2:0] REQ_PEEK3  = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_FEW   = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/bstk_core.sv =====
`default_nettype none

module bstk_core
    import bstk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       exec_fire,
    input  wire req_t       req,
    input  wire logic [4:0] stack_limit,
    output res_t            res
);

    localparam int FW        = $clog2(DEPTH + 1);
    localparam int LW        = (FW > 5) ? FW : 5;
    localparam int MEM_DEPTH = DEPTH - 3;
    localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // top three entries live in registers, the rest spill to memory
    logic [DATA_WIDTH-1:0] t0_reg, t1_reg, t2_reg;
    logic [DATA_WIDTH-1:0] t0_next, t1_next, t2_next;
    logic [FW-1:0]         fill_reg, fill_next, fill_eff;

    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] below_reg;   // entry just under t2
    logic                  mem_we;
    logic [MAW-1:0]        mem_waddr, mem_raddr;

    logic [LW-1:0] lim_eff;
    logic          full;
    logic [31:0]   read_value;
    logic [1:0]    status;

    assign lim_eff = (LW'(stack_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(stack_limit);
    assign full    = LW'(fill_reg) >= lim_eff;

    always_comb begin
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        fill_next  = fill_reg;
        mem_we     = 1'b0;
        read_value = '0;
        status     = ST_DONE;
        case (req.req_type)
            REQ_PUSH: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    t0_next   = DATA_WIDTH'(req.item_value);
                    t1_next   = t0_reg;
                    t2_next   = t1_reg;
                    mem_we    = fill_reg >= FW'(3);
                    fill_next = fill_reg + FW'(1);
                end
            end
            REQ_POP: begin
                if (fill_reg == '0) begin
                    status = ST_EMPTY;
                end else begin
                    t0_next   = t1_reg;
                    t1_next   = t2_reg;
                    t2_next   = below_reg;
                    fill_next = fill_reg - FW'(1);
                end
            end
            REQ_PEEK: begin
                if (fill_reg == '0) begin
                    status = ST_EMPTY;
                end else begin
                    read_value = 32'(t0_reg);
                end
            end
            REQ_REMOVE: begin
                if (fill_reg < FW'(3)) begin
                    status = ST_FEW;
                end else begin
                    t2_next   = below_reg;
                    fill_next = fill_reg - FW'(1);
                end
            end
            REQ_INSERT: begin
                if (fill_reg < FW'(2)) begin
                    status = ST_FEW;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    t2_next   = DATA_WIDTH'(req.item_value);
                    mem_we    = fill_reg >= FW'(3);
                    fill_next = fill_reg + FW'(1);
                end
            end
            REQ_PEEK3: begin
                if (fill_reg < FW'(3)) begin
                    status = ST_FEW;
                end else begin
                    read_value = 32'(t2_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign res.read_value = read_value;
    assign res.status     = status;
    assign res.occupancy  = 5'(fill_next);

    // old t2 spills to slot fill-3; keep the entry under the new t2 prefetched
    assign fill_eff  = exec_fire ? fill_next : fill_reg;
    assign mem_waddr = MAW'(fill_reg - FW'(3));
    assign mem_raddr = (fill_eff >= FW'(4)) ? MAW'(fill_eff - FW'(4)) : '0;

    always_ff @(posedge aclk) begin
        if (exec_fire && mem_we) begin
            mem[mem_waddr] <= t2_reg;
        end
        if (exec_fire && mem_we && (mem_waddr == mem_raddr)) begin
            below_reg <= t2_reg;
        end else begin
            below_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (exec_fire) begin
            fill_reg <= fill_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LW'(fill_reg) <= LW'(DEPTH))
        else $error("fill count above depth");

    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (status != ST_DONE) |=> $stable(fill_reg))
        else $error("refused request changed fill count");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (req.req_type == REQ_PUSH) && (status == ST_DONE)
        |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("push did not advance fill count");

    a_full_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (status == ST_FULL) |-> LW'(fill_reg) >= lim_eff)
        else $error("full reported below limit");

endmodule

`default_nettype wire

// ===== sv/bounded_stack_with_deep_ops.sv =====
// Bounded LIFO stack with push, pop, peek top, remove third, insert under
// the top two and peek third.
// Requests arrive on s_valid/s_ready/s_req; one result per request leaves on
// m_valid/m_ready/m_res with the value read, a status and the new occupancy.
// cfg_valid/cfg_ready/cfg_stack_limit writes the entry limit; write it only
// while no request is in flight. cfg_ready is always high.
// A request is captured in the input register, executed when the output
// register is free or being drained, and its result is then held on m_res.
// Throughput: one request per cycle while m_ready stays high. The top three
// entries sit in registers, deeper ones in a spill memory with one write and
// one prefetched read per cycle, so every request finishes in one update.
// Reset (aresetn low, synchronous) empties the stack and sets the limit to 16.
// When m_ready is low the result is held, one more request waits in the input
// register, and s_ready drops until the result is taken.
`default_nettype none

module bounded_stack_with_deep_ops
    import bstk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire req_t       s_req,
    output logic            m_valid,
    input  wire logic       m_ready,
    output res_t            m_res,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_stack_limit
);

    logic       in_valid_reg;
    req_t       in_req_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic [4:0] limit_reg;
    logic       exec_fire;
    res_t       exec_res;

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_res     = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_stack_limit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg <= s_req;
        end
    end

    bstk_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .exec_fire   (exec_fire),
        .req         (in_req_reg),
        .stack_limit (limit_reg),
        .res         (exec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            out_res_reg <= exec_res;
        end
    end

endmodule

`default_nettype wire
